// File: sv/itpll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itpll_pkg: shared types, constants and microcode for interval_tracking_pll
// Holds the control word layout, the datapath operations and the program ROM.
// ----------------------------------------------------------------------------
package itpll_pkg;

	// Reset values
	localparam logic signed [31:0] START_TICKS = 32'sd503000;
	localparam logic [15:0] FILTER_DIV_DEF = 16'd8;
	localparam logic [15:0] CORR_DIV_DEF   = 16'd4;
	localparam logic [15:0] TRACK_DIV_DEF  = 16'd64;
	localparam logic [19:0] MICROS_PER_SEC = 20'd1000000;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_FILTER_DIV = 2'd0;
	localparam logic [1:0] REG_CORR_DIV   = 2'd1;
	localparam logic [1:0] REG_TRACK_DIV  = 2'd2;
	localparam logic [1:0] REG_CLOCK_FREQ = 2'd3;

	// Divider geometry: 52-bit dividend shift register, two quotient bits a cycle
	localparam int DIV_W     = 52;
	localparam int SMALL_W   = 34;
	localparam int CNT_W     = 5;
	localparam logic [CNT_W-1:0] CNT_SMALL = CNT_W'(SMALL_W / 2);
	localparam logic [CNT_W-1:0] CNT_WIDE  = CNT_W'(DIV_W / 2);

	// Program steps
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] STEP_IDLE = 4'd0;
	localparam logic [PC_W-1:0] STEP_ERR  = 4'd1;
	localparam logic [PC_W-1:0] STEP_DIVK = 4'd2;
	localparam logic [PC_W-1:0] STEP_RUNK = 4'd3;
	localparam logic [PC_W-1:0] STEP_FILT = 4'd4;
	localparam logic [PC_W-1:0] STEP_RUNG = 4'd5;
	localparam logic [PC_W-1:0] STEP_INT  = 4'd6;
	localparam logic [PC_W-1:0] STEP_RUNT = 4'd7;
	localparam logic [PC_W-1:0] STEP_NOM  = 4'd8;
	localparam logic [PC_W-1:0] STEP_MUL  = 4'd9;
	localparam logic [PC_W-1:0] STEP_RUNM = 4'd10;
	localparam logic [PC_W-1:0] STEP_OUT  = 4'd11;

	// Datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD_IN,
		OP_ERR,
		OP_DIVK,
		OP_RUN,
		OP_FILT,
		OP_INT,
		OP_NOM,
		OP_MUL,
		OP_OUT
	} op_t;

	// Jump conditions
	typedef enum logic [2:0] {
		C_NONE,
		C_NO_REQ,
		C_IGN,
		C_DIV_BUSY,
		C_OUT_FULL
	} cond_t;

	// One control word
	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            last;
	} ctrl_t;

	// Program ROM
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w = '{op: OP_NOP, cond: C_NONE, target: STEP_IDLE, last: 1'b1};
		unique case (pc)
			STEP_IDLE: w = '{op: OP_LOAD_IN, cond: C_NO_REQ, target: STEP_IDLE, last: 1'b0};
			STEP_ERR:  w = '{op: OP_ERR, cond: C_IGN, target: STEP_MUL, last: 1'b0};
			STEP_DIVK: w = '{op: OP_DIVK, cond: C_NONE, target: STEP_IDLE, last: 1'b0};
			STEP_RUNK: w = '{op: OP_RUN, cond: C_DIV_BUSY, target: STEP_RUNK, last: 1'b0};
			STEP_FILT: w = '{op: OP_FILT, cond: C_NONE, target: STEP_IDLE, last: 1'b0};
			STEP_RUNG: w = '{op: OP_RUN, cond: C_DIV_BUSY, target: STEP_RUNG, last: 1'b0};
			STEP_INT:  w = '{op: OP_INT, cond: C_NONE, target: STEP_IDLE, last: 1'b0};
			STEP_RUNT: w = '{op: OP_RUN, cond: C_DIV_BUSY, target: STEP_RUNT, last: 1'b0};
			STEP_NOM:  w = '{op: OP_NOM, cond: C_NONE, target: STEP_IDLE, last: 1'b0};
			STEP_MUL:  w = '{op: OP_MUL, cond: C_NONE, target: STEP_IDLE, last: 1'b0};
			STEP_RUNM: w = '{op: OP_RUN, cond: C_DIV_BUSY, target: STEP_RUNM, last: 1'b0};
			STEP_OUT:  w = '{op: OP_OUT, cond: C_OUT_FULL, target: STEP_OUT, last: 1'b1};
			default:   w = '{op: OP_NOP, cond: C_NONE, target: STEP_IDLE, last: 1'b1};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// File: sv/interval_tracking_pll.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interval_tracking_pll: integer PLL tracking the interval between pulses
// Filters the interval error, corrects the internal interval and slowly moves
// the nominal interval; reports nominal in ticks and in microseconds.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | dir | meaning
//  in       | in_valid, in_ready, measured_ticks       | in  | one measured interval
//  out      | out_valid, out_ready, nominal_ticks,     | out | one result per request
//           | interval_micros, ignored                 |     |
//  cfg      | psel, penable, pwrite, paddr, pwdata,    | in  | register access, 4 regs
//           | prdata, pready                           |     |
//
//  A request runs through the microcode program and its shared divider: three
//  34-bit signed divides and one 52-bit divide at two quotient bits a cycle, plus
//  one step per operation; a zero measurement goes straight to the 52-bit divide.
//  in_ready is high only while the sequencer sits in its idle step.
//  A result waiting in the output register does not block the next request;
//  the program stalls in its final step only if that register is still full.
//  arst_n clears the state to nominal = internal = 503000, filtered error 0.
// ----------------------------------------------------------------------------
module interval_tracking_pll (
	input  wire                clk,
	input  wire                arst_n,
	// input channel
	input  wire                in_valid,
	output logic               in_ready,
	input  wire  [30:0]        measured_ticks,
	// output channel
	output logic               out_valid,
	input  wire                out_ready,
	output logic signed [31:0] nominal_ticks,
	output logic [31:0]        interval_micros,
	output logic               ignored,
	// configuration port
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire  [3:0]         paddr,
	input  wire  [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int DW = itpll_pkg::DIV_W;
	localparam int SW = itpll_pkg::SMALL_W;

	// Configuration registers
	logic [15:0] filter_div_q;
	logic [15:0] corr_div_q;
	logic [15:0] track_div_q;
	logic [31:0] clock_freq_q;

	// Sequencer
	logic [itpll_pkg::PC_W-1:0] pc_q;
	itpll_pkg::ctrl_t           uc;
	logic                       cond_hit;
	logic                       in_fire;
	logic                       out_full;

	// Datapath state
	logic signed [31:0] nom_q;
	logic signed [31:0] int_q;
	logic signed [31:0] filt_q;
	logic [30:0]        meas_q;
	logic               ign_q;
	logic signed [34:0] acc_q;
	logic               zero_q;

	// Shared divider
	logic [DW-1:0]                   quo_q;
	logic [31:0]                     rem_q;
	logic [31:0]                     div_q;
	logic                            sign_q;
	logic [itpll_pkg::CNT_W-1:0]     cnt_q;

	logic [32:0]  t1, t2;
	logic         ge1, ge2;
	logic [31:0]  r1, r2;
	logic [31:0]  q_lo;
	logic [31:0]  q_signed;
	logic [31:0]  micros_sat;
	logic [15:0]  kdiv, gdiv, tdiv;
	logic [33:0]  acc_mag;
	logic [31:0]  filt_new;
	logic [32:0]  filt_mag;
	logic [32:0]  filtq_mag;
	logic [50:0]  product;
	logic         cfg_wr;

	// APB access
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		unique case (paddr[3:2])
			itpll_pkg::REG_FILTER_DIV: prdata = {16'd0, filter_div_q};
			itpll_pkg::REG_CORR_DIV:   prdata = {16'd0, corr_div_q};
			itpll_pkg::REG_TRACK_DIV:  prdata = {16'd0, track_div_q};
			itpll_pkg::REG_CLOCK_FREQ: prdata = clock_freq_q;
			default:                   prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_div_q <= itpll_pkg::FILTER_DIV_DEF;
			corr_div_q   <= itpll_pkg::CORR_DIV_DEF;
			track_div_q  <= itpll_pkg::TRACK_DIV_DEF;
			clock_freq_q <= 32'd0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				itpll_pkg::REG_FILTER_DIV: filter_div_q <= pwdata[15:0];
				itpll_pkg::REG_CORR_DIV:   corr_div_q   <= pwdata[15:0];
				itpll_pkg::REG_TRACK_DIV:  track_div_q  <= pwdata[15:0];
				itpll_pkg::REG_CLOCK_FREQ: clock_freq_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Zero divisor register acts as its default
	assign kdiv = (filter_div_q == 16'd0) ? itpll_pkg::FILTER_DIV_DEF : filter_div_q;
	assign gdiv = (corr_div_q == 16'd0) ? itpll_pkg::CORR_DIV_DEF : corr_div_q;
	assign tdiv = (track_div_q == 16'd0) ? itpll_pkg::TRACK_DIV_DEF : track_div_q;

	// Control word and jump decision
	assign uc       = itpll_pkg::ucode(pc_q);
	assign in_ready = (pc_q == itpll_pkg::STEP_IDLE);
	assign in_fire  = in_valid & in_ready;
	assign out_full = out_valid & ~out_ready;

	always_comb begin
		case (uc.cond)
			itpll_pkg::C_NO_REQ:   cond_hit = ~in_fire;
			itpll_pkg::C_IGN:      cond_hit = ign_q;
			itpll_pkg::C_DIV_BUSY: cond_hit = (cnt_q != itpll_pkg::CNT_W'(1));
			itpll_pkg::C_OUT_FULL: cond_hit = out_full;
			default:               cond_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= itpll_pkg::STEP_IDLE;
		end else if (cond_hit) begin
			pc_q <= uc.target;
		end else if (uc.last) begin
			pc_q <= itpll_pkg::STEP_IDLE;
		end else begin
			pc_q <= pc_q + itpll_pkg::PC_W'(1);
		end
	end

	// Divider: two restoring steps per cycle
	assign t1  = {rem_q, quo_q[DW-1]};
	assign ge1 = (t1 >= {1'b0, div_q});
	assign r1  = ge1 ? 32'(t1 - {1'b0, div_q}) : t1[31:0];
	assign t2  = {r1, quo_q[DW-2]};
	assign ge2 = (t2 >= {1'b0, div_q});
	assign r2  = ge2 ? 32'(t2 - {1'b0, div_q}) : t2[31:0];

	// Signed quotient, kept mod 2^32 since every use wraps
	assign q_lo       = quo_q[31:0];
	assign q_signed   = sign_q ? (~q_lo + 32'd1) : q_lo;
	assign micros_sat = (|quo_q[DW-1:32]) ? 32'hFFFF_FFFF : q_lo;

	// Operand magnitudes
	assign acc_mag   = acc_q[34] ? 34'(-acc_q) : 34'(acc_q);
	assign filt_new  = filt_q + q_signed;
	assign filt_mag  = filt_new[31] ? (33'd0 - {1'b1, filt_new}) : {1'b0, filt_new};
	assign filtq_mag = filt_q[31] ? (33'd0 - {1'b1, filt_q}) : {1'b0, filt_q};
	assign product   = nom_q[30:0] * itpll_pkg::MICROS_PER_SEC;

	// Datapath payload registers
	always_ff @(posedge clk) begin
		case (uc.op)
			itpll_pkg::OP_LOAD_IN: begin
				if (in_fire) begin
					meas_q <= measured_ticks;
					ign_q  <= (measured_ticks == 31'd0);
				end
			end
			itpll_pkg::OP_ERR: begin
				acc_q <= $signed({4'd0, meas_q}) - $signed({{3{int_q[31]}}, int_q})
					- $signed({{3{filt_q[31]}}, filt_q});
			end
			itpll_pkg::OP_DIVK: begin
				sign_q <= acc_q[34];
				quo_q  <= {acc_mag, (DW-SW)'(0)};
				rem_q  <= 32'd0;
				div_q  <= {16'd0, kdiv};
				cnt_q  <= itpll_pkg::CNT_SMALL;
			end
			itpll_pkg::OP_RUN: begin
				quo_q <= {quo_q[DW-3:0], ge1, ge2};
				rem_q <= r2;
				cnt_q <= cnt_q - itpll_pkg::CNT_W'(1);
			end
			itpll_pkg::OP_FILT: begin
				sign_q <= filt_new[31];
				quo_q  <= {SW'(filt_mag), (DW-SW)'(0)};
				rem_q  <= 32'd0;
				div_q  <= {16'd0, gdiv};
				cnt_q  <= itpll_pkg::CNT_SMALL;
			end
			itpll_pkg::OP_INT: begin
				sign_q <= filt_q[31];
				quo_q  <= {SW'(filtq_mag), (DW-SW)'(0)};
				rem_q  <= 32'd0;
				div_q  <= {16'd0, tdiv};
				cnt_q  <= itpll_pkg::CNT_SMALL;
			end
			itpll_pkg::OP_MUL: begin
				zero_q <= (clock_freq_q == 32'd0) | nom_q[31];
				quo_q  <= {1'b0, product};
				rem_q  <= 32'd0;
				div_q  <= clock_freq_q;
				cnt_q  <= itpll_pkg::CNT_WIDE;
			end
			default: ;
		endcase
	end

	// Tracked state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nom_q  <= itpll_pkg::START_TICKS;
			int_q  <= itpll_pkg::START_TICKS;
			filt_q <= 32'sd0;
		end else begin
			case (uc.op)
				itpll_pkg::OP_FILT: filt_q <= filt_new;
				itpll_pkg::OP_INT:  int_q  <= nom_q + q_signed;
				itpll_pkg::OP_NOM:  nom_q  <= nom_q + q_signed;
				default: ;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (uc.op == itpll_pkg::OP_OUT && !out_full) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uc.op == itpll_pkg::OP_OUT && !out_full) begin
			nominal_ticks   <= nom_q;
			interval_micros <= zero_q ? 32'd0 : micros_sat;
			ignored         <= ign_q;
		end
	end

`ifndef NO_ASSERTIONS
	// A new result only ever comes from the final program step
	a_out_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pc_q) == itpll_pkg::STEP_OUT)
		else $error("result raised outside the output step");

	// Divider never runs with an exhausted count
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == itpll_pkg::STEP_RUNK || pc_q == itpll_pkg::STEP_RUNG ||
		 pc_q == itpll_pkg::STEP_RUNT || pc_q == itpll_pkg::STEP_RUNM) |-> cnt_q != '0)
		else $error("divider stepped with zero count");

	// A zero measurement leaves the tracked state alone
	a_ignored_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == itpll_pkg::STEP_ERR && ign_q) |=>
		(pc_q == itpll_pkg::STEP_MUL && $stable(nom_q) && $stable(int_q) && $stable(filt_q)))
		else $error("ignored measurement changed state");
`endif

endmodule
`default_nettype wire

// File: sim/tb_interval_tracking_pll.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_tracking_pll: self-checking testbench for interval_tracking_pll
// Streams measured intervals through the valid/ready request channel, programs
// all four registers over APB between phases, and checks every result against
// a local model of the tracking loop (filter, correction, nominal tracking,
// microsecond conversion with saturation).
// ----------------------------------------------------------------------------
module tb_interval_tracking_pll;

	localparam int          QUIET_LIMIT = 2000;
	localparam logic [30:0] MEAS_MAX    = 31'h7FFF_FFFF;
	localparam int          PHASE_ITEMS = 117;

	typedef struct packed {
		logic signed [31:0] nominal;
		logic [31:0]        micros;
		logic               ign;
	} pll_result_t;

	// DUT inputs, known from time zero
	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic [30:0] measured_ticks = '0;
	logic        out_ready      = 1'b0;
	logic        psel           = 1'b0;
	logic        penable        = 1'b0;
	logic        pwrite         = 1'b0;
	logic [3:0]  paddr          = '0;
	logic [31:0] pwdata         = '0;

	// DUT outputs
	wire               in_ready;
	wire               out_valid;
	wire signed [31:0] nominal_ticks;
	wire [31:0]        interval_micros;
	wire               ignored;
	wire [31:0]        prdata;
	wire               pready;

	// Shadow copy of the registers
	logic [15:0] filt_div_q  = itpll_pkg::FILTER_DIV_DEF;
	logic [15:0] corr_div_q  = itpll_pkg::CORR_DIV_DEF;
	logic [15:0] track_div_q = itpll_pkg::TRACK_DIV_DEF;
	logic [31:0] freq_q      = '0;

	// Loop state of the tracking model
	logic signed [31:0] nominal_q  = itpll_pkg::START_TICKS;
	logic signed [31:0] internal_q = itpll_pkg::START_TICKS;
	logic signed [31:0] filtered_q = '0;

	pll_result_t expected_results[$];
	pll_result_t want;
	int          error_count = 0;
	int          quiet_cycles = 0;
	int          stall_left = 0;
	bit          idle_on = 1'b1;

	interval_tracking_pll dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.measured_ticks (measured_ticks),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.nominal_ticks  (nominal_ticks),
		.interval_micros(interval_micros),
		.ignored        (ignored),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Tracking model: one step per accepted request, pushes the expected result
	task automatic advance_pll(input logic [30:0] value);
		longint      kdiv, gdiv, tdiv, err, sum;
		logic [63:0] us;
		pll_result_t r;
		if (value != 0) begin
			kdiv = (filt_div_q == 0) ? longint'(itpll_pkg::FILTER_DIV_DEF)
				: longint'(filt_div_q);
			gdiv = (corr_div_q == 0) ? longint'(itpll_pkg::CORR_DIV_DEF)
				: longint'(corr_div_q);
			tdiv = (track_div_q == 0) ? longint'(itpll_pkg::TRACK_DIV_DEF)
				: longint'(track_div_q);
			err  = longint'(value) - longint'(internal_q);
			sum  = longint'(filtered_q) + (err - longint'(filtered_q)) / kdiv;
			filtered_q = sum[31:0];
			// internal uses the nominal from before this step
			sum  = longint'(nominal_q) + longint'(filtered_q) / gdiv;
			internal_q = sum[31:0];
			sum  = longint'(nominal_q) + longint'(filtered_q) / tdiv;
			nominal_q = sum[31:0];
		end
		r.nominal = nominal_q;
		r.ign     = (value == 0);
		if (freq_q == 0 || nominal_q < 0) begin
			r.micros = '0;
		end else begin
			us = {32'd0, nominal_q} * 64'(itpll_pkg::MICROS_PER_SEC) / {32'd0, freq_q};
			r.micros = (us > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : us[31:0];
		end
		expected_results.push_back(r);
	endtask

	// Send one measurement, with an optional idle burst in front
	task automatic send_measurement(input logic [30:0] value);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		measured_ticks <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		advance_pll(value);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// One APB write: setup cycle, then access until pready
	task automatic write_register(input logic [1:0] index, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (index)
			itpll_pkg::REG_FILTER_DIV: filt_div_q  = value[15:0];
			itpll_pkg::REG_CORR_DIV:   corr_div_q  = value[15:0];
			itpll_pkg::REG_TRACK_DIV:  track_div_q = value[15:0];
			itpll_pkg::REG_CLOCK_FREQ: freq_q      = value;
			default: ;
		endcase
	endtask

	// Drain, then rewrite every register
	task automatic program_pll(input logic [31:0] k, input logic [31:0] g,
			input logic [31:0] t, input logic [31:0] f);
		wait_for_results();
		write_register(itpll_pkg::REG_FILTER_DIV, k);
		write_register(itpll_pkg::REG_CORR_DIV, g);
		write_register(itpll_pkg::REG_TRACK_DIV, t);
		write_register(itpll_pkg::REG_CLOCK_FREQ, f);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mostly jittered intervals around the tracked nominal, plus zeros,
	// extremes and raw random values
	function automatic logic [30:0] pick_measurement();
		longint      target;
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 60) begin
			if ($urandom_range(0, 3) == 0)
				target = longint'(nominal_q) + longint'($urandom_range(0, 400000)) - 200000;
			else
				target = longint'(nominal_q) + longint'($urandom_range(0, 4000)) - 2000;
			if (target < 1) target = 1;
			if (target > longint'(MEAS_MAX)) target = longint'(MEAS_MAX);
			return target[30:0];
		end
		if (sel < 70) return '0;
		if (sel < 80) begin
			case ($urandom_range(0, 3))
				0: return 31'd1;
				1: return MEAS_MAX;
				2: return 31'd2;
				default: return MEAS_MAX - 31'd1;
			endcase
		end
		return 31'($urandom);
	endfunction

	// Reset defaults: divisors 8/4/64, frequency 0 so micros stays 0
	task automatic test_reset_state();
		send_measurement(31'd503000);
		send_measurement(31'd0);
		send_measurement(31'd503250);
		send_measurement(31'd502750);
	endtask

	// Divisor registers at 0 act as defaults; frequency 1 saturates micros
	task automatic test_zero_divisors();
		program_pll(32'd0, 32'd0, 32'd0, 32'd1);
		send_measurement(31'd600000);
		send_measurement(31'd0);
		send_measurement(31'd1);
		send_measurement(MEAS_MAX);
		send_measurement(31'd450000);
	endtask

	// Extreme gains with alternating extreme intervals: negative nominal, wraps
	task automatic test_extreme_gains();
		program_pll(32'd1, 32'd65535, 32'd1, 32'd1000);
		for (int i = 0; i < 4; i++) begin
			send_measurement(MEAS_MAX);
			send_measurement((i == 2) ? 31'd0 : 31'd1);
		end
		program_pll(32'd65535, 32'd1, 32'd65535, 32'hFFFF_FFFF);
		send_measurement(31'd2);
		send_measurement(MEAS_MAX);
		send_measurement(31'd0);
	endtask

	// Random intervals over several register settings; last phase at full rate
	task automatic test_random_tracking();
		logic [31:0] k, g, t, f;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin k = 32'd8; g = 32'd4; t = 32'd64; f = 32'd1000000; end
				1: begin k = $urandom; g = $urandom; t = $urandom; f = $urandom; end
				2: begin k = 32'd65535; g = 32'd65535; t = 32'd65535; f = 32'hFFFF_FFFF; end
				3: begin k = 32'd1; g = 32'd1; t = 32'd1; f = 32'd1; end
				4: begin k = $urandom; g = $urandom; t = $urandom; f = $urandom; end
				5: begin k = 32'd0; g = 32'd0; t = 32'd0; f = 32'd16000000; end
				6: begin
					k = 32'd1; g = 32'd65535; t = 32'd1;
					f = $urandom_range(1, 100000);
				end
				default: begin
					k = {16'($urandom_range(0, 65535)), 16'($urandom_range(1, 16))};
					g = {16'($urandom_range(0, 65535)), 16'($urandom_range(1, 16))};
					t = {16'($urandom_range(0, 65535)), 16'($urandom_range(1, 128))};
					f = 32'd48000000;
				end
			endcase
			program_pll(k, g, t, f);
			idle_on = (phase < 7);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_measurement(pick_measurement());
		end
	endtask

	// Result side back-pressure in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 11) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result: nominal=%0d micros=%0d ignored=%0b",
						nominal_ticks, interval_micros, ignored);
			end else begin
				want = expected_results.pop_front();
				if (nominal_ticks !== want.nominal || interval_micros !== want.micros ||
						ignored !== want.ign) begin
					error_count++;
					if (error_count <= 10)
						$display("mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
							want.nominal, want.micros, want.ign,
							nominal_ticks, interval_micros, ignored);
				end
			end
		end
	end

	// Watchdog: cycles without any accepted request or result
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_zero_divisors();
		test_extreme_gains();
		test_random_tracking();
		wait_for_results();
		repeat (120) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
